// ===== rtl/hlos_pkg.sv =====
// Shared types, constants and the obstacle lookup for the horizon line-of-sight block.
`timescale 1ns / 1ps

package hlos_pkg;

    localparam int LANES       = 4;
    localparam int HEIGHT_W    = 16;
    localparam int EYE_W       = 12;
    localparam int TYPE_W      = 8;
    localparam int DIST_W      = 6;
    localparam int CLUTTER_W   = 10;
    localparam int LEVEL_W     = 18;
    localparam int RISE_W      = 19;
    localparam int PROD_W      = 27;
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_GROUND_CLUTTER = 2'd0;
    localparam logic [1:0] REG_TALL_COVER     = 2'd1;
    localparam logic [1:0] REG_MID_COVER      = 2'd2;

    localparam logic signed [CLUTTER_W-1:0] GROUND_CLUTTER_RESET = -10'sd15;
    localparam logic signed [CLUTTER_W-1:0] TALL_COVER_RESET     = 10'sd30;
    localparam logic signed [CLUTTER_W-1:0] MID_COVER_RESET      = 10'sd10;

    localparam logic signed [LEVEL_W-1:0] EYE_OFFSET    = 18'sd15;
    localparam logic signed [RISE_W-1:0]  HORIZON_RESET = -19'sd1000;
    localparam logic [DIST_W-1:0]         RUN_RESET     = 6'd1;

    typedef struct packed {
        logic                        ray_start;
        logic signed [HEIGHT_W-1:0]  observer_ground;
        logic [EYE_W-1:0]            eye_height;
        logic signed [HEIGHT_W-1:0]  height_0;
        logic signed [HEIGHT_W-1:0]  height_1;
        logic signed [HEIGHT_W-1:0]  height_2;
        logic signed [HEIGHT_W-1:0]  height_3;
        logic [TYPE_W-1:0]           type_0;
        logic [TYPE_W-1:0]           type_1;
        logic [TYPE_W-1:0]           type_2;
        logic [TYPE_W-1:0]           type_3;
        logic [LANES-1:0]            lane_in_map;
    } step_t;

    typedef struct packed {
        logic [LANES-1:0]  visible_mask;
        logic [DIST_W-1:0] step_distance;
    } result_t;

    typedef struct packed {
        logic signed [CLUTTER_W-1:0] ground_clutter;
        logic signed [CLUTTER_W-1:0] tall_cover;
        logic signed [CLUTTER_W-1:0] mid_cover;
    } cfg_t;

    // One classified step waiting for the horizon unit
    typedef struct packed {
        logic                              ray_start;
        logic [DIST_W-1:0]                 step_dist;
        logic [LANES-1:0]                  mask;
        logic [LANES-1:0][LEVEL_W-1:0]     dh;
        logic [LANES-1:0][LEVEL_W-1:0]     top;
    } queue_entry_t;

    typedef struct packed {
        logic         valid;
        queue_entry_t entry;
    } queue_port_t;

    // Obstacle height for a terrain type code
    function automatic logic signed [CLUTTER_W-1:0] obstacle_for(
        input logic [TYPE_W-1:0] ty,
        input cfg_t              cfg
    );
        logic signed [CLUTTER_W-1:0] h;
        if (ty inside {8'd6, 8'd7, 8'd8, [8'd26:8'd29], 8'd31})
        begin
            h = cfg.tall_cover;
        end
        else if (ty inside {[8'd32:8'd63]})
        begin
            h = cfg.mid_cover;
        end
        else
        begin
            h = cfg.ground_clutter;
        end
        return h;
    endfunction

endpackage

// ===== rtl/hlos_if.sv =====
// Valid/ready channel interfaces for step items and result items.
`timescale 1ns / 1ps

interface hlos_step_if;
    import hlos_pkg::*;

    logic  valid;
    logic  ready;
    step_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface hlos_result_if;
    import hlos_pkg::*;

    logic    valid;
    logic    ready;
    result_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/hlos_front.sv =====
// Front end: accepts step items, tracks eye level and distance, forms height differences.
`timescale 1ns / 1ps

module hlos_front #(
    parameter int MAX_RADIUS = 50
) (
    input  logic                 clk,
    input  logic                 rst_n,
    hlos_step_if.sink            step,
    input  hlos_pkg::cfg_t       cfg,
    input  logic                 queue_full,
    output hlos_pkg::queue_port_t push
);
    import hlos_pkg::*;

    localparam logic [DIST_W-1:0] MAX_DIST = DIST_W'(MAX_RADIUS);

    logic signed [LEVEL_W-1:0] eye_level_reg;
    logic signed [LEVEL_W-1:0] eye_level_next;
    logic [DIST_W-1:0]         dist_reg;
    logic [DIST_W-1:0]         dist_next;

    logic signed [LEVEL_W-1:0] eye_new;
    logic signed [LEVEL_W-1:0] eye_use;
    logic [DIST_W-1:0]         dist_use;
    logic                      accept;

    logic signed [HEIGHT_W-1:0] heights [LANES];
    logic [TYPE_W-1:0]          types [LANES];
    logic signed [LEVEL_W-1:0]  dh [LANES];
    logic signed [LEVEL_W-1:0]  top [LANES];

    assign step.ready = !queue_full;
    assign accept     = step.valid && !queue_full;

    // Pick the eye level and distance that this step sees
    always_comb
    begin
        eye_new  = LEVEL_W'(step.payload.observer_ground)
                 + LEVEL_W'(signed'({1'b0, step.payload.eye_height}))
                 - EYE_OFFSET;
        eye_use  = step.payload.ray_start ? eye_new : eye_level_reg;
        dist_use = step.payload.ray_start ? RUN_RESET : dist_reg;
    end

    // Height over eye, with and without the obstacle on top
    always_comb
    begin
        heights[0] = step.payload.height_0;
        heights[1] = step.payload.height_1;
        heights[2] = step.payload.height_2;
        heights[3] = step.payload.height_3;
        types[0]   = step.payload.type_0;
        types[1]   = step.payload.type_1;
        types[2]   = step.payload.type_2;
        types[3]   = step.payload.type_3;
        for (int i = 0; i < LANES; i++)
        begin
            dh[i]  = LEVEL_W'(heights[i]) - eye_use;
            top[i] = dh[i] + LEVEL_W'(obstacle_for(types[i], cfg));
        end
    end

    // Build the queue entry
    always_comb
    begin
        push.valid           = accept;
        push.entry.ray_start = step.payload.ray_start;
        push.entry.step_dist = dist_use;
        push.entry.mask      = step.payload.lane_in_map;
        for (int i = 0; i < LANES; i++)
        begin
            push.entry.dh[i]  = dh[i];
            push.entry.top[i] = top[i];
        end
    end

    // Latch the eye level and advance the distance, saturating at the ray radius
    always_comb
    begin
        eye_level_next = eye_level_reg;
        dist_next      = dist_reg;
        if (accept)
        begin
            eye_level_next = eye_use;
            dist_next      = (dist_use >= MAX_DIST) ? MAX_DIST : dist_use + 6'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eye_level_reg <= '0;
            dist_reg      <= RUN_RESET;
        end
        else
        begin
            eye_level_reg <= eye_level_next;
            dist_reg      <= dist_next;
        end
    end

    a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
        dist_reg != '0 && (dist_reg <= MAX_DIST || dist_reg == RUN_RESET))
        else $error("step distance left its range");

    a_ray_start_dist: assert property (@(posedge clk) disable iff (!rst_n)
        accept && step.payload.ray_start |=> dist_reg == ((MAX_DIST > RUN_RESET) ?
            RUN_RESET + 6'd1 : MAX_DIST))
        else $error("distance not restarted by ray start");

    a_push_dist: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid && !step.payload.ray_start |-> push.entry.step_dist == dist_reg)
        else $error("queued distance differs from tracked distance");

endmodule

// ===== rtl/hlos_queue.sv =====
// Short queue between the classifying front end and the horizon unit.
`timescale 1ns / 1ps

module hlos_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  hlos_pkg::queue_port_t push,
    input  logic                  pop,
    output logic                  full,
    output hlos_pkg::queue_port_t head
);
    import hlos_pkg::*;

    queue_entry_t      mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.entry = mem[rd_ptr_reg];
    assign do_push    = push.valid && !full;
    assign do_pop     = pop && head.valid;

    // Move the pointers and the fill count
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the entry
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push.entry;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> !full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head.valid)
        else $error("pop from empty queue");

endmodule

// ===== rtl/hlos_back.sv =====
// Back end: per-lane horizon compare and update, result register.
`timescale 1ns / 1ps

module hlos_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  hlos_pkg::queue_port_t head,
    output logic                  pop,
    hlos_result_if.source         result
);
    import hlos_pkg::*;

    logic signed [RISE_W-1:0] rise_reg [LANES];
    logic signed [RISE_W-1:0] rise_next [LANES];
    logic [DIST_W-1:0]        run_reg [LANES];
    logic [DIST_W-1:0]        run_next [LANES];

    logic                     res_valid_reg;
    logic                     res_valid_next;
    result_t                  res_reg;
    result_t                  res_next;

    logic signed [RISE_W-1:0] rise_cur [LANES];
    logic [DIST_W-1:0]        run_cur [LANES];
    logic signed [PROD_W-1:0] lhs_vis [LANES];
    logic signed [PROD_W-1:0] lhs_top [LANES];
    logic signed [PROD_W-1:0] rhs [LANES];
    logic [LANES-1:0]         vis;
    logic [LANES-1:0]         raise;

    assign pop            = head.valid && (!res_valid_reg || result.ready);
    assign result.valid   = res_valid_reg;
    assign result.payload = res_reg;

    // Compare each lane's slope against its horizon by cross-multiplication
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            rise_cur[i] = head.entry.ray_start ? HORIZON_RESET : rise_reg[i];
            run_cur[i]  = head.entry.ray_start ? RUN_RESET : run_reg[i];
            rhs[i]      = PROD_W'(rise_cur[i])
                        * PROD_W'(signed'({1'b0, head.entry.step_dist}));
            lhs_vis[i]  = PROD_W'(signed'(head.entry.dh[i]))
                        * PROD_W'(signed'({1'b0, run_cur[i]}));
            lhs_top[i]  = PROD_W'(signed'(head.entry.top[i]))
                        * PROD_W'(signed'({1'b0, run_cur[i]}));
            vis[i]      = head.entry.mask[i] && (lhs_vis[i] > rhs[i]);
            raise[i]    = head.entry.mask[i] && (lhs_top[i] > rhs[i]);
        end
    end

    // Raise horizons and load the result on pop; drop result valid once it is taken
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            rise_next[i] = rise_reg[i];
            run_next[i]  = run_reg[i];
            if (pop)
            begin
                rise_next[i] = raise[i] ? RISE_W'(signed'(head.entry.top[i])) : rise_cur[i];
                run_next[i]  = raise[i] ? head.entry.step_dist : run_cur[i];
            end
        end
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        if (pop)
        begin
            res_valid_next         = 1'b1;
            res_next.visible_mask  = vis;
            res_next.step_distance = head.entry.step_dist;
        end
        else if (result.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            for (int i = 0; i < LANES; i++)
            begin
                rise_reg[i] <= HORIZON_RESET;
                run_reg[i]  <= RUN_RESET;
            end
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            for (int i = 0; i < LANES; i++)
            begin
                rise_reg[i] <= rise_next[i];
                run_reg[i]  <= run_next[i];
            end
        end
    end

    // Hold the result payload
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg[0] != '0 && run_reg[1] != '0 && run_reg[2] != '0 && run_reg[3] != '0)
        else $error("horizon run is zero");

    a_vis_in_map: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (res_reg.visible_mask & ~$past(head.entry.mask)) == '0)
        else $error("visible bit on lane off the map");

    a_pop_loads: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> res_valid_reg && res_reg.step_distance == $past(head.entry.step_dist))
        else $error("popped item did not reach the result register");

endmodule

// ===== rtl/horizon_line_of_sight.sv =====
// Top level of the horizon line-of-sight stepper: channels, register port, front/queue/back.
`timescale 1ns / 1ps

//  Channel   Dir   Handshake               Carries
//  step      in    valid/ready             one ray step: four lane samples + observer
//  result    out   valid/ready             visible_mask and step_distance per step
//  apb       in    psel/penable, pready=1  three 10-bit obstacle heights at 0x0/0x4/0x8
//
//  One step item is taken per cycle while the queue is not full; each step is written
//  into the queue, and its result is loaded into the output register when it is popped.
//  The horizon unit compares and updates every lane in the cycle it pops an item,
//  which sets the one-item-per-cycle rate; the front end feeds it through a 2-entry queue.
//  Reset clears horizons to -1000/1, distance to 1, eye level to 0; no clearing pass.
//  A stalled result holds in its register; the queue takes up to two more steps, then
//  drops ready until the result is taken.

module horizon_line_of_sight #(
    parameter int MAX_RADIUS = 50
) (
    input  logic                           clk,
    input  logic                           rst_n,
    hlos_step_if.sink                      step,
    hlos_result_if.source                  result,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [hlos_pkg::ADDR_W-1:0]    paddr,
    input  logic [hlos_pkg::DATA_W-1:0]    pwdata,
    output logic [hlos_pkg::DATA_W-1:0]    prdata,
    output logic                           pready
);
    import hlos_pkg::*;

    cfg_t        cfg_reg;
    cfg_t        cfg_next;
    logic        cfg_write;
    logic [1:0]  reg_index;

    queue_port_t push;
    queue_port_t head;
    logic        queue_full;
    logic        pop;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite;

    // Decode register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (reg_index)
                REG_GROUND_CLUTTER: cfg_next.ground_clutter = pwdata[CLUTTER_W-1:0];
                REG_TALL_COVER:     cfg_next.tall_cover     = pwdata[CLUTTER_W-1:0];
                REG_MID_COVER:      cfg_next.mid_cover      = pwdata[CLUTTER_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    // Read back sign-extended
    always_comb
    begin
        case (reg_index)
            REG_GROUND_CLUTTER: prdata = DATA_W'(cfg_reg.ground_clutter);
            REG_TALL_COVER:     prdata = DATA_W'(cfg_reg.tall_cover);
            REG_MID_COVER:      prdata = DATA_W'(cfg_reg.mid_cover);
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ground_clutter <= GROUND_CLUTTER_RESET;
            cfg_reg.tall_cover     <= TALL_COVER_RESET;
            cfg_reg.mid_cover      <= MID_COVER_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    hlos_front #(
        .MAX_RADIUS (MAX_RADIUS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .cfg        (cfg_reg),
        .queue_full (queue_full),
        .push       (push)
    );

    hlos_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .full  (queue_full),
        .head  (head)
    );

    hlos_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .pop    (pop),
        .result (result)
    );

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the horizon line-of-sight stepper.
`timescale 1ns / 1ps

module tb;
    import hlos_pkg::*;

    localparam int RADIUS_LIMIT = 50;
    localparam int QUIET_LIMIT  = 4000;
    localparam int PHASES       = 5;
    localparam int PHASE_ITEMS  = 370;

    // Scoreboard: tracks horizons per lane and queues the expected result of each step
    class sight_scoreboard;
        cfg_t                       cover_cfg;
        logic signed [RISE_W-1:0]   rise [LANES];
        logic [DIST_W-1:0]          run_len [LANES];
        logic [DIST_W-1:0]          cur_dist;
        logic signed [LEVEL_W-1:0]  eye_level;
        result_t                    expected_q [$];
        int                         errors;

        function new();
            cover_cfg.ground_clutter = GROUND_CLUTTER_RESET;
            cover_cfg.tall_cover     = TALL_COVER_RESET;
            cover_cfg.mid_cover      = MID_COVER_RESET;
            clear_horizons();
            cur_dist  = DIST_W'(1);
            eye_level = '0;
            errors    = 0;
        endfunction

        function void clear_horizons();
            for (int l = 0; l < LANES; l++)
            begin
                rise[l]    = HORIZON_RESET;
                run_len[l] = RUN_RESET;
            end
        endfunction

        // Obstacle height added on top of the ground for a terrain type
        function longint obstacle(logic [TYPE_W-1:0] ty);
            if (ty == 8'd6 || ty == 8'd7 || ty == 8'd8 || (ty >= 8'd26 && ty <= 8'd29)
                || ty == 8'd31)
            begin
                return longint'(cover_cfg.tall_cover);
            end
            if (ty >= 8'd32 && ty <= 8'd63)
            begin
                return longint'(cover_cfg.mid_cover);
            end
            return longint'(cover_cfg.ground_clutter);
        endfunction

        function void note_step(step_t s);
            logic signed [HEIGHT_W-1:0] hts [LANES];
            logic [TYPE_W-1:0]          tys [LANES];
            longint                     dh, t, rhs, run, d;
            result_t                    r;
            hts[0] = s.height_0;
            hts[1] = s.height_1;
            hts[2] = s.height_2;
            hts[3] = s.height_3;
            tys[0] = s.type_0;
            tys[1] = s.type_1;
            tys[2] = s.type_2;
            tys[3] = s.type_3;
            // Latch the eye and restart every ray
            if (s.ray_start)
            begin
                eye_level = LEVEL_W'(longint'($signed(s.observer_ground))
                                     + longint'(s.eye_height) - longint'(EYE_OFFSET));
                clear_horizons();
                cur_dist = DIST_W'(1);
            end
            d = longint'(cur_dist);
            r.visible_mask  = '0;
            r.step_distance = cur_dist;
            // Compare each lane against its horizon by cross-multiplication
            for (int l = 0; l < LANES; l++)
            begin
                if (s.lane_in_map[l])
                begin
                    dh  = longint'(hts[l]) - longint'(eye_level);
                    run = longint'(run_len[l]);
                    rhs = longint'(rise[l]) * d;
                    if (dh * run > rhs)
                    begin
                        r.visible_mask[l] = 1'b1;
                    end
                    t = dh + obstacle(tys[l]);
                    if (t * run > rhs)
                    begin
                        rise[l]    = RISE_W'(t);
                        run_len[l] = cur_dist;
                    end
                end
            end
            expected_q.insert(expected_q.size(), r);
            // Advance the distance, holding at the radius
            if (cur_dist >= RADIUS_LIMIT)
            begin
                cur_dist = DIST_W'(RADIUS_LIMIT);
            end
            else
            begin
                cur_dist = cur_dist + 1'b1;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_q.size() == 0)
            begin
                $error("unexpected result: visible_mask=%b step_distance=%0d",
                       got.visible_mask, got.step_distance);
                errors++;
                return;
            end
            want = expected_q[0];
            expected_q.delete(0);
            if (got.visible_mask !== want.visible_mask)
            begin
                $error("visible_mask: expected %b, actual %b",
                       want.visible_mask, got.visible_mask);
                errors++;
            end
            if (got.step_distance !== want.step_distance)
            begin
                $error("step_distance: expected %0d, actual %0d",
                       want.step_distance, got.step_distance);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                clk;
    logic                rst_n    = 1'b0;
    logic                tx_valid = 1'b0;
    step_t               tx_item  = '0;
    logic                rx_ready = 1'b0;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [ADDR_W-1:0]   paddr    = '0;
    logic [DATA_W-1:0]   pwdata   = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                idle_on  = 1'b0;
    int                  rx_stall = 0;
    int                  quiet_cycles = 0;
    sight_scoreboard     sb = new();

    hlos_step_if   step_ch ();
    hlos_result_if result_ch ();

    assign step_ch.valid   = tx_valid;
    assign step_ch.payload = tx_item;
    assign result_ch.ready = rx_ready;

    horizon_line_of_sight #(
        .MAX_RADIUS (RADIUS_LIMIT)
    ) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step_ch),
        .result  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 95)
        begin
            return $urandom_range(4, 8);
        end
        return $urandom_range(12, 40);
    endfunction

    function automatic int spread(int m);
        return int'($urandom_range(0, 2 * m)) - m;
    endfunction

    function automatic int clamp_height(int v);
        if (v > 32767)
        begin
            return 32767;
        end
        if (v < -32768)
        begin
            return -32768;
        end
        return v;
    endfunction

    // Weight terrain types toward the cover classes
    function automatic int pick_type();
        int tall_codes [8] = '{6, 7, 8, 26, 27, 28, 29, 31};
        int r;
        r = $urandom_range(0, 9);
        if (r < 3)
        begin
            return $urandom_range(0, 255);
        end
        if (r < 5)
        begin
            return tall_codes[$urandom_range(0, 7)];
        end
        if (r < 7)
        begin
            return $urandom_range(32, 63);
        end
        return $urandom_range(0, 31);
    endfunction

    function automatic step_t make_step(int rs, int og, int eh, int h0, int h1, int h2,
                                        int h3, int t0, int t1, int t2, int t3, int mask);
        step_t s;
        s.ray_start       = 1'(rs);
        s.observer_ground = HEIGHT_W'(og);
        s.eye_height      = EYE_W'(eh);
        s.height_0        = HEIGHT_W'(h0);
        s.height_1        = HEIGHT_W'(h1);
        s.height_2        = HEIGHT_W'(h2);
        s.height_3        = HEIGHT_W'(h3);
        s.type_0          = TYPE_W'(t0);
        s.type_1          = TYPE_W'(t1);
        s.type_2          = TYPE_W'(t2);
        s.type_3          = TYPE_W'(t3);
        s.lane_in_map     = LANES'(mask);
        return s;
    endfunction

    // Present one step item and hold it until it is taken
    task automatic send_step(step_t s);
        int gap;
        gap = (idle_on && $urandom_range(0, 2) == 0) ? gap_len() : 0;
        if (gap > 0)
        begin
            tx_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tx_valid <= 1'b1;
        tx_item  <= s;
        @(posedge clk);
        while (!step_ch.ready) @(posedge clk);
    endtask

    // Drop valid and wait until every expected result is back
    task automatic drain_results();
        tx_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
    endtask

    // Write one obstacle register, then read it back
    task automatic reg_write(logic [1:0] idx, logic signed [CLUTTER_W-1:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {{(DATA_W - CLUTTER_W){val[CLUTTER_W-1]}}, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (prdata[CLUTTER_W-1:0] !== val)
        begin
            $error("register %0d readback: expected %0d, actual %0d",
                   idx, val, $signed(prdata[CLUTTER_W-1:0]));
            sb.errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_GROUND_CLUTTER: sb.cover_cfg.ground_clutter = val;
            REG_TALL_COVER:     sb.cover_cfg.tall_cover     = val;
            REG_MID_COVER:      sb.cover_cfg.mid_cover      = val;
            default:            ;
        endcase
    endtask

    task automatic set_cover(int clutter, int tall, int mid);
        drain_results();
        repeat (4) @(posedge clk);
        reg_write(REG_GROUND_CLUTTER, CLUTTER_W'(clutter));
        reg_write(REG_TALL_COVER, CLUTTER_W'(tall));
        reg_write(REG_MID_COVER, CLUTTER_W'(mid));
    endtask

    // Extremes, each type class, ties, off-map lanes, steps before any ray start
    task automatic run_directed();
        send_step(make_step(0, 0, 0, 0, -1000, -999, 32767, 6, 32, 64, 255, 4'hF));
        send_step(make_step(0, 123, 45, -32768, 32767, -1, 1, 0, 1, 2, 3, 4'h0));
        send_step(make_step(1, -32768, 0, -32768, 32767, -32768, 0, 7, 8, 26, 29, 4'hF));
        send_step(make_step(0, 0, 0, -32768, -32000, 32767, 0, 27, 28, 31, 63, 4'hF));
        send_step(make_step(1, 32767, 4095, -32768, 32767, 0, -1, 27, 28, 31, 63, 4'hF));
        send_step(make_step(0, 0, 0, 32767, 32767, 32767, 32767, 9, 25, 30, 64, 4'hF));
        send_step(make_step(1, 0, 15, -1000, -999, -1001, 100, 5, 9, 25, 0, 4'hF));
        send_step(make_step(0, 0, 0, -2000, -2000, 0, 170, 30, 33, 62, 128, 4'hA));
        send_step(make_step(0, 32767, 4095, 500, 500, 500, 500, 200, 254, 65, 31, 4'h5));
        send_step(make_step(0, -1, 0, 300, -300, 1000, 255, 6, 32, 31, 63, 4'hF));
        send_step(make_step(1, -1, 4095, 21845, -21846, 21845, -21846, 170, 85, 170, 85,
                            4'h6));
        send_step(make_step(0, 0, 0, -21846, 21845, -21846, 21845, 85, 170, 85, 170,
                            4'h9));
        send_step(make_step(1, 21845, 2730, 21845, 21845, 21845, 21845, 8, 26, 40, 100,
                            4'hF));
        send_step(make_step(0, 0, 0, 30000, 22000, 21000, 25000, 29, 31, 50, 1, 4'hF));
    endtask

    // Mostly well-formed rays over rolling terrain, some noise items
    task automatic run_random(int count);
        int done, groups, og, eh, eye, len, n, group_mask, mask;
        int slope [LANES];
        int h [LANES];
        done   = 0;
        groups = 0;
        while (done < count)
        begin
            idle_on <= ($urandom_range(0, 3) != 0);
            if (groups == 8)
            begin
                drain_results();
            end
            if ($urandom_range(0, 99) < 85)
            begin
                og  = ($urandom_range(0, 9) < 7) ? spread(2000) : spread(32768);
                eh  = ($urandom_range(0, 9) < 6) ? $urandom_range(0, 100)
                                                 : $urandom_range(0, 4095);
                eye = og + eh - 15;
                len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 30)
                                                   : $urandom_range(40, 70);
                group_mask = ($urandom_range(0, 3) != 0) ? 15 : $urandom_range(0, 15);
                for (int l = 0; l < LANES; l++)
                begin
                    slope[l] = spread(200);
                end
                for (int k = 1; k <= len; k++)
                begin
                    for (int l = 0; l < LANES; l++)
                    begin
                        slope[l] += spread(30);
                        if ($urandom_range(0, 19) == 0)
                        begin
                            h[l] = spread(32768);
                        end
                        else
                        begin
                            h[l] = clamp_height(eye + slope[l] * ((k > 50) ? 50 : k)
                                                + spread(50));
                        end
                    end
                    mask = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : group_mask;
                    send_step(make_step(int'(k == 1), og, eh, h[0], h[1], h[2], h[3],
                                        pick_type(), pick_type(), pick_type(), pick_type(),
                                        mask));
                end
                done += len;
            end
            else
            begin
                n = $urandom_range(1, 4);
                repeat (n)
                begin
                    send_step(make_step($urandom_range(0, 1), spread(32768),
                                        $urandom_range(0, 4095), spread(32768),
                                        spread(32768), spread(32768), spread(32768),
                                        $urandom_range(0, 255), $urandom_range(0, 255),
                                        $urandom_range(0, 255), $urandom_range(0, 255),
                                        $urandom_range(0, 15)));
                end
                done += n;
            end
            groups++;
        end
    endtask

    // Result side: random stalls while idling is on
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rx_ready <= 1'b0;
        end
        else if (rx_stall > 0)
        begin
            rx_ready <= 1'b0;
            rx_stall <= rx_stall - 1;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            rx_ready <= 1'b0;
            rx_stall <= gap_len() - 1;
        end
        else
        begin
            rx_ready <= 1'b1;
        end
    end

    // Observe both channels and watch for a hang
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (step_ch.valid && step_ch.ready)
            begin
                sb.note_step(step_ch.payload);
            end
            if (result_ch.valid && result_ch.ready)
            begin
                sb.check_result(result_ch.payload);
            end
            if ((step_ch.valid && step_ch.ready) || (result_ch.valid && result_ch.ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("horizon_line_of_sight: mismatch");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        for (int ph = 0; ph < PHASES; ph++)
        begin
            // Move the obstacle heights between phases, extremes included
            case (ph)
                1: set_cover($urandom_range(0, 1023), $urandom_range(0, 1023),
                             $urandom_range(0, 1023));
                2: set_cover(-512, -512, -512);
                3: set_cover(511, 511, 511);
                4: set_cover(511, -512, 0);
                default: ;
            endcase
            run_random(PHASE_ITEMS);
        end
        drain_results();
        repeat (12) @(posedge clk);
        if (sb.errors == 0)
        begin
            $display("horizon_line_of_sight: match");
        end
        else
        begin
            $display("horizon_line_of_sight: mismatch");
        end
        $finish;
    end

endmodule
